// ===== rtl/spdm_pkg.sv =====
`timescale 1ns / 1ps

package spdm_pkg;

   // term layout
   localparam int WORD_BITS     = 64;
   localparam int EXP_WORDS     = 4;
   localparam int WORD_SEL_BITS = 2;
   localparam int INDEX_BITS    = 16;
   localparam int FBITS_BITS    = 7;
   localparam int SHIFT_BITS    = 6;
   localparam int PADDR_BITS    = 5;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [EXP_WORDS-1:0][WORD_BITS-1:0] exp_vec_type;

   // live configuration seen by the datapath
   typedef struct packed {
      logic [WORD_BITS-1:0]     modulus;
      logic [FBITS_BITS-1:0]    field_bits;
      logic [WORD_SEL_BITS-1:0] field_word;
      logic [SHIFT_BITS-1:0]    field_shift;
   } cfg_type;

endpackage

// ===== rtl/sparse_poly_derivative_mod_n.sv =====
`timescale 1ns / 1ps

// a term runs exponent reduction, coefficient reduction, then the product;
//   a zero field is dropped at once, a multiple of n after the exponent reduction
// a new term is taken only in idle; one shared 65-bit compare/subtract unit
//   runs two 64-step reductions and a double-and-add product, one step a cycle
// a result still waiting in the output register stalls the next one in its last state
// reset: synchronous, active high; clears the term count and loads register defaults
module sparse_poly_derivative_mod_n (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [63:0]                     req_coefficient,
   input  logic [63:0]                     req_exp_word_0,
   input  logic [63:0]                     req_exp_word_1,
   input  logic [63:0]                     req_exp_word_2,
   input  logic [63:0]                     req_exp_word_3,
   input  logic                            req_last_term,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [63:0]                     rsp_out_coefficient,
   output logic [63:0]                     rsp_out_exp_0,
   output logic [63:0]                     rsp_out_exp_1,
   output logic [63:0]                     rsp_out_exp_2,
   output logic [63:0]                     rsp_out_exp_3,
   output logic [15:0]                     rsp_term_index,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [spdm_pkg::PADDR_BITS-1:0] csr_paddr,
   input  logic [63:0]                     csr_pwdata,
   output logic [63:0]                     csr_prdata,
   output logic                            csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_E,
      ST_RED_C,
      ST_MUL_DBL,
      ST_MUL_ADD,
      ST_FIN
   } state_type;

   localparam logic [5:0] STEP_LAST = '1;

   spdm_pkg::cfg_type     cfg;
   spdm_pkg::exp_vec_type req_words;
   spdm_pkg::exp_vec_type dec_words;
   spdm_pkg::word_type    field_exp;

   state_type                          state_ff, state_in;
   spdm_pkg::word_type                 acc_ff, acc_in;
   spdm_pkg::word_type                 opnd_ff, opnd_in;
   spdm_pkg::word_type                 hold_ff, hold_in;
   spdm_pkg::word_type                 addend_ff, addend_in;
   logic [5:0]                         step_ff, step_in;
   logic                               last_ff, last_in;
   spdm_pkg::exp_vec_type              words_ff, words_in;
   logic [spdm_pkg::INDEX_BITS-1:0]    count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   spdm_pkg::word_type                 rsp_coef_ff, rsp_coef_in;
   spdm_pkg::exp_vec_type              rsp_exp_ff, rsp_exp_in;
   logic [15:0]                        rsp_idx_ff, rsp_idx_in;

   logic [spdm_pkg::WORD_BITS:0] unit_x;
   spdm_pkg::word_type           unit_y;
   logic                         req_fire;
   logic                         out_free;

   assign req_words = {req_exp_word_3, req_exp_word_2, req_exp_word_1, req_exp_word_0};

   spdm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spdm_field u_field (
      .exp_words (req_words),
      .cfg       (cfg),
      .field_exp (field_exp),
      .dec_words (dec_words)
   );

   spdm_modred u_modred (
      .x       (unit_x),
      .modulus (cfg.modulus),
      .y       (unit_y)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // operand select for the shared unit
   always_comb begin
      case (state_ff)
         ST_MUL_DBL: unit_x = {acc_ff, 1'b0};
         ST_MUL_ADD: unit_x = {1'b0, acc_ff} + {1'b0, addend_ff};
         default:    unit_x = {acc_ff, opnd_ff[spdm_pkg::WORD_BITS-1]};
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      opnd_in      = opnd_ff;
      hold_in      = hold_ff;
      addend_in    = addend_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      words_in     = words_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_coef_in  = rsp_coef_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_idx_in   = rsp_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hold_in  = req_coefficient;
               words_in = dec_words;
               last_in  = req_last_term;
               acc_in   = '0;
               opnd_in  = field_exp;
               step_in  = '0;
               if (field_exp == '0) begin
                  // zero exponent: term vanishes
                  if (req_last_term) begin
                     count_in = '0;
                  end
               end else begin
                  state_in = ST_RED_E;
               end
            end
         end

         // exponent mod n, one bit a cycle
         ST_RED_E: begin
            acc_in  = unit_y;
            opnd_in = opnd_ff << 1;
            step_in = step_ff + 6'd1;
            if (step_ff == STEP_LAST) begin
               if (unit_y == '0) begin
                  if (last_ff) begin
                     count_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  acc_in   = '0;
                  opnd_in  = hold_ff;
                  hold_in  = unit_y;
                  state_in = ST_RED_C;
               end
            end
         end

         // coefficient mod n
         ST_RED_C: begin
            acc_in  = unit_y;
            opnd_in = opnd_ff << 1;
            step_in = step_ff + 6'd1;
            if (step_ff == STEP_LAST) begin
               addend_in = unit_y;
               acc_in    = '0;
               opnd_in   = hold_ff;
               state_in  = ST_MUL_DBL;
            end
         end

         // double-and-add product, msb first
         ST_MUL_DBL: begin
            acc_in = unit_y;
            if (opnd_ff[spdm_pkg::WORD_BITS-1]) begin
               state_in = ST_MUL_ADD;
            end else begin
               opnd_in = opnd_ff << 1;
               step_in = step_ff + 6'd1;
               if (step_ff == STEP_LAST) begin
                  state_in = ST_FIN;
               end
            end
         end

         ST_MUL_ADD: begin
            acc_in  = unit_y;
            opnd_in = opnd_ff << 1;
            step_in = step_ff + 6'd1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_MUL_DBL;
            end
         end

         // hand off to the output register once it is free
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = acc_ff;
               rsp_exp_in   = words_ff;
               rsp_idx_in   = count_ff[15:0];
               count_in     = last_ff ? '0 : count_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      opnd_ff     <= opnd_in;
      hold_ff     <= hold_in;
      addend_ff   <= addend_in;
      step_ff     <= step_in;
      last_ff     <= last_in;
      words_ff    <= words_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_exp_ff  <= rsp_exp_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_coefficient = rsp_coef_ff;
   assign rsp_out_exp_0       = rsp_exp_ff[0];
   assign rsp_out_exp_1       = rsp_exp_ff[1];
   assign rsp_out_exp_2       = rsp_exp_ff[2];
   assign rsp_out_exp_3       = rsp_exp_ff[3];
   assign rsp_term_index      = rsp_idx_ff;

`ifndef NO_ASSERTIONS
   // a waiting result is never overwritten
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FIN))
      else $error("result register overwritten while waiting");

   // accumulator stays reduced during the product
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MUL_DBL || state_ff == ST_MUL_ADD) && cfg.modulus != '0)
         |-> (acc_ff < cfg.modulus))
      else $error("accumulator not below modulus");

   // a new result carries the count at its hand-off
   a_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> (rsp_valid_ff && rsp_term_index == $past(count_ff)))
      else $error("term index does not match count");
`endif

endmodule

// ===== rtl/spdm_csr.sv =====
`timescale 1ns / 1ps

module spdm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [spdm_pkg::PADDR_BITS-1:0] csr_paddr,
   input  logic [spdm_pkg::WORD_BITS-1:0]  csr_pwdata,
   output logic [spdm_pkg::WORD_BITS-1:0]  csr_prdata,
   output logic                            csr_pready,
   output spdm_pkg::cfg_type               cfg
);

   // register indexes, 8 bytes apart
   typedef enum logic [1:0] {
      REG_MODULUS     = 2'd0,
      REG_FIELD_BITS  = 2'd1,
      REG_FIELD_WORD  = 2'd2,
      REG_FIELD_SHIFT = 2'd3
   } reg_idx_type;

   spdm_pkg::cfg_type cfg_ff, cfg_in;
   reg_idx_type       reg_idx;
   logic              wr_en;

   assign reg_idx    = reg_idx_type'(csr_paddr[4:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MODULUS:     cfg_in.modulus     = csr_pwdata;
            REG_FIELD_BITS:  cfg_in.field_bits  = csr_pwdata[spdm_pkg::FBITS_BITS-1:0];
            REG_FIELD_WORD:  cfg_in.field_word  = csr_pwdata[spdm_pkg::WORD_SEL_BITS-1:0];
            REG_FIELD_SHIFT: cfg_in.field_shift = csr_pwdata[spdm_pkg::SHIFT_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_MODULUS:     csr_prdata = cfg_ff.modulus;
         REG_FIELD_BITS:  csr_prdata = 64'(cfg_ff.field_bits);
         REG_FIELD_WORD:  csr_prdata = 64'(cfg_ff.field_word);
         REG_FIELD_SHIFT: csr_prdata = 64'(cfg_ff.field_shift);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.modulus     <= 64'd2;
         cfg_ff.field_bits  <= 7'd8;
         cfg_ff.field_word  <= '0;
         cfg_ff.field_shift <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/spdm_field.sv =====
`timescale 1ns / 1ps

module spdm_field (
   input  spdm_pkg::exp_vec_type exp_words,
   input  spdm_pkg::cfg_type     cfg,
   output spdm_pkg::word_type    field_exp,
   output spdm_pkg::exp_vec_type dec_words
);

   logic [spdm_pkg::FBITS_BITS-1:0] width_eff;
   spdm_pkg::word_type              mask;
   spdm_pkg::word_type              sel_word;
   spdm_pkg::word_type              unit_step;

   // clamp field width to 1..64, then extract the variable's exponent
   always_comb begin
      if (cfg.field_bits == '0) begin
         width_eff = 7'd1;
      end else if (cfg.field_bits > 7'd64) begin
         width_eff = 7'd64;
      end else begin
         width_eff = cfg.field_bits;
      end
      mask      = {spdm_pkg::WORD_BITS{1'b1}} >> (7'd64 - width_eff);
      sel_word  = exp_words[cfg.field_word];
      field_exp = (sel_word >> cfg.field_shift) & mask;
   end

   // decrement the field in place, wrapping inside the word
   assign unit_step = spdm_pkg::word_type'(1) << cfg.field_shift;

   always_comb begin
      for (int w = 0; w < spdm_pkg::EXP_WORDS; w++) begin
         if (spdm_pkg::WORD_SEL_BITS'(w) == cfg.field_word) begin
            dec_words[w] = exp_words[w] - unit_step;
         end else begin
            dec_words[w] = exp_words[w];
         end
      end
   end

endmodule

// ===== rtl/spdm_modred.sv =====
`timescale 1ns / 1ps

// conditional subtract: x < 2n in, x mod n out; modulus zero means 2^64
module spdm_modred (
   input  logic [spdm_pkg::WORD_BITS:0]   x,
   input  spdm_pkg::word_type             modulus,
   output spdm_pkg::word_type             y
);

   logic [spdm_pkg::WORD_BITS:0] diff;

   assign diff = x - {1'b0, modulus};

   always_comb begin
      if (modulus == '0) begin
         y = x[spdm_pkg::WORD_BITS-1:0];
      end else if (x >= {1'b0, modulus}) begin
         y = diff[spdm_pkg::WORD_BITS-1:0];
      end else begin
         y = x[spdm_pkg::WORD_BITS-1:0];
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import spdm_pkg::*;

   typedef enum int {
      REG_MODULUS     = 0,
      REG_FIELD_BITS  = 1,
      REG_FIELD_WORD  = 2,
      REG_FIELD_SHIFT = 3
   } csr_reg_e;

   typedef struct {
      word_type    coefficient;
      exp_vec_type exp_words;
      logic        last_term;
   } poly_term_t;

   typedef struct {
      word_type    coefficient;
      exp_vec_type exp_words;
      logic [15:0] index;
   } deriv_term_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [63:0]           req_coefficient = '0;
   logic [63:0]           req_exp_word_0 = '0;
   logic [63:0]           req_exp_word_1 = '0;
   logic [63:0]           req_exp_word_2 = '0;
   logic [63:0]           req_exp_word_3 = '0;
   logic                  req_last_term = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [63:0]           rsp_out_coefficient;
   logic [63:0]           rsp_out_exp_0;
   logic [63:0]           rsp_out_exp_1;
   logic [63:0]           rsp_out_exp_2;
   logic [63:0]           rsp_out_exp_3;
   logic [15:0]           rsp_term_index;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [PADDR_BITS-1:0] csr_paddr = '0;
   logic [63:0]           csr_pwdata = '0;
   logic [63:0]           csr_prdata;
   logic                  csr_pready;

   // predictor state: register copy and output term count
   cfg_type     cfg_shadow = '{modulus: 64'd2, field_bits: 7'd8, field_word: 2'd0,
                               field_shift: 6'd0};
   logic [15:0] term_count = '0;

   poly_term_t  pending_terms[$];
   deriv_term_t expected_terms[$];
   poly_term_t  held_term;
   deriv_term_t want;
   int          queued_total = 0;
   int          accepted_total = 0;
   int          mismatch_count = 0;
   int          send_gap = 0;
   int          recv_stall = 0;
   bit          quiet_run = 1'b0;

   sparse_poly_derivative_mod_n uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_coefficient     (req_coefficient),
      .req_exp_word_0      (req_exp_word_0),
      .req_exp_word_1      (req_exp_word_1),
      .req_exp_word_2      (req_exp_word_2),
      .req_exp_word_3      (req_exp_word_3),
      .req_last_term       (req_last_term),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_coefficient (rsp_out_coefficient),
      .rsp_out_exp_0       (rsp_out_exp_0),
      .rsp_out_exp_1       (rsp_out_exp_1),
      .rsp_out_exp_2       (rsp_out_exp_2),
      .rsp_out_exp_3       (rsp_out_exp_3),
      .rsp_term_index      (rsp_term_index),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // mask of the variable's exponent field, width clamped to 1..64
   function automatic word_type field_mask();
      int unsigned width;
      width = (cfg_shadow.field_bits == 0) ? 1 :
              (cfg_shadow.field_bits > 64) ? 64 : cfg_shadow.field_bits;
      return {64{1'b1}} >> (64 - width);
   endfunction

   // derivative of one term; queues the output term unless it vanishes
   function automatic void derive_term(input poly_term_t t);
      word_type    n;
      word_type    e;
      word_type    e_red;
      logic [127:0] prod;
      deriv_term_t d;
      n = cfg_shadow.modulus;
      e = (t.exp_words[cfg_shadow.field_word] >> cfg_shadow.field_shift) & field_mask();
      e_red = (n == 0) ? e : e % n;
      if (e != 0 && e_red != 0) begin
         // zero modulus stands for 2^64: plain wrapping product
         if (n == 0) begin
            d.coefficient = t.coefficient * e;
         end else begin
            prod = {64'd0, t.coefficient % n} * {64'd0, e_red};
            d.coefficient = word_type'(prod % {64'd0, n});
         end
         d.exp_words = t.exp_words;
         d.exp_words[cfg_shadow.field_word] = t.exp_words[cfg_shadow.field_word]
                                              - (64'd1 << cfg_shadow.field_shift);
         d.index = term_count;
         term_count = term_count + 16'd1;
         expected_terms.push_back(d);
      end
      if (t.last_term)
         term_count = '0;
   endfunction

   function automatic int draw_gap();
      return quiet_run ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic void check_field(input string name, input word_type exp_val,
                                       input word_type act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %h, got %h", name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            derive_term(held_term);
            accepted_total++;
            send_gap = draw_gap();
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_terms.size() != 0) begin
               held_term = pending_terms.pop_front();
               req_coefficient <= held_term.coefficient;
               req_exp_word_0  <= held_term.exp_words[0];
               req_exp_word_1  <= held_term.exp_words[1];
               req_exp_word_2  <= held_term.exp_words[2];
               req_exp_word_3  <= held_term.exp_words[3];
               req_last_term   <= held_term.last_term;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_terms.size() == 0) begin
               $error("result with no term expected: term_index %0d", rsp_term_index);
               mismatch_count++;
            end else begin
               want = expected_terms.pop_front();
               check_field("out_coefficient", want.coefficient, rsp_out_coefficient);
               check_field("out_exp_0", want.exp_words[0], rsp_out_exp_0);
               check_field("out_exp_1", want.exp_words[1], rsp_out_exp_1);
               check_field("out_exp_2", want.exp_words[2], rsp_out_exp_2);
               check_field("out_exp_3", want.exp_words[3], rsp_out_exp_3);
               check_field("term_index", word_type'(want.index), word_type'(rsp_term_index));
            end
            recv_stall = draw_gap();
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // setup and access cycle, then mirror the register
   task automatic csr_write(input csr_reg_e r, input word_type value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PADDR_BITS'(int'(r) * 8);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (r)
         REG_MODULUS:     cfg_shadow.modulus     = value;
         REG_FIELD_BITS:  cfg_shadow.field_bits  = value[FBITS_BITS-1:0];
         REG_FIELD_WORD:  cfg_shadow.field_word  = value[WORD_SEL_BITS-1:0];
         REG_FIELD_SHIFT: cfg_shadow.field_shift = value[SHIFT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_fields(input word_type n, input int unsigned fb,
                                 input int unsigned fw, input int unsigned fs);
      csr_write(REG_MODULUS, n);
      csr_write(REG_FIELD_BITS, word_type'(fb));
      csr_write(REG_FIELD_WORD, word_type'(fw));
      csr_write(REG_FIELD_SHIFT, word_type'(fs));
      @(negedge clock);
   endtask

   task automatic queue_term(input poly_term_t t);
      pending_terms.push_back(t);
      queued_total++;
   endtask

   // wait for acceptance and results, then let dropped terms drain
   task automatic settle_phase();
      int k;
      while (accepted_total != queued_total)
         @(posedge clock);
      for (k = 0; k < 3000 && expected_terms.size() != 0; k++)
         @(posedge clock);
      repeat (300) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic poly_term_t make_term(input word_type c, input word_type w0,
                                            input word_type w1, input word_type w2,
                                            input word_type w3, input logic last);
      poly_term_t t;
      t.coefficient  = c;
      t.exp_words[0] = w0;
      t.exp_words[1] = w1;
      t.exp_words[2] = w2;
      t.exp_words[3] = w3;
      t.last_term    = last;
      return t;
   endfunction

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic word_type random_modulus();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return word_type'($urandom_range(1, 20));
         2: return rand_word();
         3: return {64{1'b1}} - word_type'($urandom_range(0, 3));
         4: return 64'd1 << $urandom_range(1, 63);
         default: return word_type'($urandom_range(2, 1000));
      endcase
   endfunction

   // mostly reduced coefficients; in half the terms the field is forced to zero, to a multiple of n or small
   function automatic poly_term_t random_term();
      poly_term_t  t;
      int unsigned kind;
      int unsigned fw;
      int unsigned fs;
      word_type    n;
      word_type    m;
      word_type    v;
      n  = cfg_shadow.modulus;
      fw = cfg_shadow.field_word;
      fs = cfg_shadow.field_shift;
      m  = field_mask();
      for (int w = 0; w < EXP_WORDS; w++)
         t.exp_words[w] = rand_word();
      kind = $urandom_range(0, 15);
      t.coefficient = rand_word();
      if (n != 0 && kind != 0)
         t.coefficient = t.coefficient % n;
      if (kind >= 1 && kind <= 8) begin
         if (kind <= 2)
            v = '0;
         else if (kind <= 4)
            v = n * word_type'($urandom_range(1, 5));
         else
            v = word_type'($urandom_range(1, 3));
         t.exp_words[fw] = (t.exp_words[fw] & ~(m << fs)) | ((v & m) << fs);
      end
      t.last_term = ($urandom_range(0, 7) == 0);
      return t;
   endfunction

   // stimulus
   initial begin
      int p;
      int i;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: n = 2, 8-bit field at bit 0 of word 0
      queue_term(make_term(64'd0, 64'd1, 64'd0, 64'd0, 64'd0, 1'b0));
      queue_term(make_term(64'd1, 64'hFF, '1, '1, '1, 1'b0));
      queue_term(make_term(64'd1, 64'd2, 64'd5, 64'd0, 64'd0, 1'b0));
      queue_term(make_term(64'd1, 64'h100, 64'd0, 64'd0, 64'd0, 1'b0));
      queue_term(make_term(64'd3, 64'd3, 64'd0, 64'd0, 64'd0, 1'b1));
      queue_term(make_term('1, '1, '1, '1, '1, 1'b0));
      settle_phase();

      // n = 2^64: product wraps, full-word field in the top word
      program_fields(64'd0, 64, 3, 0);
      queue_term(make_term('1, 64'd0, 64'd0, 64'd0, '1, 1'b0));
      queue_term(make_term(rand_word(), rand_word(), rand_word(), rand_word(), 64'd0, 1'b0));
      queue_term(make_term(64'h8000_0000_0000_0000, 64'd0, 64'd0, 64'd0, 64'd2, 1'b1));
      settle_phase();

      // largest n, width zero read as one bit, field at bit 63
      program_fields('1, 0, 1, 63);
      queue_term(make_term('1 - 64'd1, 64'd0, 64'h8000_0000_0000_0000, 64'd0, 64'd0, 1'b0));
      queue_term(make_term('1, 64'd0, '1, 64'd0, 64'd0, 1'b0));
      queue_term(make_term(64'd5, '1, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1, 1'b1));
      settle_phase();

      // n = 1: every term vanishes
      program_fields(64'd1, 16, 2, 8);
      queue_term(make_term(64'd0, '1, '1, '1, '1, 1'b0));
      queue_term(make_term(64'd0, 64'd0, 64'd0, 64'h1200, 64'd0, 1'b0));
      queue_term(make_term(64'd0, 64'd0, 64'd0, 64'h100, 64'd0, 1'b1));
      settle_phase();

      // oversize width clamped to 64, field running past bit 63
      program_fields(64'd7, 127, 2, 40);
      queue_term(make_term(64'd6, 64'd0, 64'd0, '1, 64'd0, 1'b0));
      queue_term(make_term(64'd6, 64'd0, 64'd0, 64'h0000_0100_0000_0000, 64'd0, 1'b0));
      queue_term(make_term('1, '1, '1, 64'h0000_0300_0000_0000, '1, 1'b0));
      settle_phase();

      // random phases with random settings
      for (p = 0; p < 10; p++) begin
         program_fields(random_modulus(),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(1, 16),
                        $urandom_range(0, 3), $urandom_range(0, 63));
         quiet_run = ($urandom_range(0, 3) == 0);
         for (i = 0; i < 90; i++)
            queue_term(random_term());
         settle_phase();
      end

      if (expected_terms.size() != 0) begin
         $error("%0d derivative terms never arrived", expected_terms.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
